// ===== hdl/assert_macros.svh =====
// Assertion helpers used by psrl_ctrl. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hdl/psrl_pkg.sv =====
package psrl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;
    localparam int LIMIT_W  = 8;
    localparam int COUNT_W  = LIMIT_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WINDOW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd30;

    // Request and result payloads
    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic [TIME_W-1:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic allowed;
        logic tracked;
    } t_out_item;

    // Live configuration
    typedef struct packed {
        logic [WINDOW_W-1:0] window_seconds;
        logic [LIMIT_W-1:0]  request_limit;
    } t_cfg;

    // One tracked source
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  window_start;
    } t_entry;

    // Sequencer to table memory
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_entry           wr_entry;
    } t_tbl_req;

endpackage

// ===== hdl/psrl_table.sv =====
module psrl_table (
    input  logic              i_clk,
    input  psrl_pkg::t_tbl_req i_req,
    output psrl_pkg::t_entry   o_rd_entry
);
    import psrl_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_entry;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_entry;
        end
    end

    // Read one entry, hold the data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_entry <= r_mem[i_req.rd_idx];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== hdl/psrl_ctrl.sv =====
`include "assert_macros.svh"

module psrl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psrl_pkg::t_cfg      i_cfg,
    input  logic                i_req_valid,
    input  psrl_pkg::t_in_item  i_req,
    output logic                o_busy,
    output logic                o_res_valid,
    output psrl_pkg::t_out_item o_res,
    input  logic                i_res_take,
    output psrl_pkg::t_tbl_req  o_tbl,
    input  psrl_pkg::t_entry    i_rd_entry
);
    import psrl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_MISS   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]         r_state,   n_state;
    logic [ADDR_W-1:0]  r_addr,    n_addr;
    logic [TIME_W-1:0]  r_now,     n_now;
    logic [CNT_W-1:0]   r_idx,     n_idx;
    logic               r_pend,    n_pend;
    logic [IDX_W-1:0]   r_pidx,    n_pidx;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic               r_expired, n_expired;
    logic               r_allowed, n_allowed;
    logic               r_tracked, n_tracked;
    logic [CNT_W-1:0]   r_used,    n_used;

    logic               issue;
    logic               match;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] limit_ext;
    logic [COUNT_W-1:0] cap;
    logic [COUNT_W-1:0] new_count;
    logic               has_room;

    // Scan, compare and window arithmetic
    always_comb begin
        issue     = (r_state == S_SCAN) && (r_idx < r_used);
        match     = (r_state == S_SCAN) && r_pend && (i_rd_entry.address == r_addr);
        elapsed   = r_now - i_rd_entry.window_start;
        limit_ext = {1'b0, i_cfg.request_limit};
        cap       = limit_ext + COUNT_W'(1);
        new_count = (i_rd_entry.count < cap) ? (i_rd_entry.count + COUNT_W'(1))
                                             : i_rd_entry.count;
        has_room  = r_used < CNT_W'(TABLE_DEPTH);
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_now     = r_now;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_hit_idx = r_hit_idx;
        n_expired = r_expired;
        n_allowed = r_allowed;
        n_tracked = r_tracked;
        n_used    = r_used;

        o_tbl.rd_en    = 1'b0;
        o_tbl.rd_idx   = r_idx[IDX_W-1:0];
        o_tbl.wr_en    = 1'b0;
        o_tbl.wr_idx   = r_hit_idx;
        o_tbl.wr_entry = '{address: r_addr, count: COUNT_W'(1), window_start: r_now};

        unique case (r_state)
            S_IDLE: begin
                // Capture request and start the scan at entry zero
                if (i_req_valid) begin
                    n_addr  = i_req.source_address;
                    n_now   = i_req.time_now;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read one entry per cycle, compare the one read last cycle
                if (match) begin
                    n_hit_idx = r_pidx;
                    n_state   = S_CHECK;
                end else if (issue) begin
                    o_tbl.rd_en = 1'b1;
                    n_pend      = 1'b1;
                    n_pidx      = r_idx[IDX_W-1:0];
                    n_idx       = r_idx + CNT_W'(1);
                end else if (!r_pend) begin
                    n_state = S_MISS;
                end
            end
            S_CHECK: begin
                // Wrap-around age of the window
                n_expired = elapsed > {{(TIME_W-WINDOW_W){1'b0}}, i_cfg.window_seconds};
                n_state   = S_UPDATE;
            end
            S_UPDATE: begin
                // Restart the window or count the request
                o_tbl.wr_en = 1'b1;
                n_tracked   = 1'b1;
                if (r_expired) begin
                    n_allowed = 1'b1;
                end else begin
                    o_tbl.wr_entry.count        = new_count;
                    o_tbl.wr_entry.window_start = i_rd_entry.window_start;
                    n_allowed                   = new_count <= limit_ext;
                end
                n_state = S_DONE;
            end
            S_MISS: begin
                // Append while there is room; always allow
                n_allowed = 1'b1;
                n_tracked = has_room;
                if (has_room) begin
                    o_tbl.wr_en  = 1'b1;
                    o_tbl.wr_idx = r_used[IDX_W-1:0];
                    n_used       = r_used + CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register takes it
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_pend  <= n_pend;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_now     <= n_now;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_hit_idx <= n_hit_idx;
        r_expired <= n_expired;
        r_allowed <= n_allowed;
        r_tracked <= n_tracked;
    end

    assign o_busy            = r_state != S_IDLE;
    assign o_res_valid       = r_state == S_DONE;
    assign o_res.allowed     = r_allowed;
    assign o_res.tracked     = r_tracked;

    `ASSERT_NEVER(a_used_bound, i_clk, i_rst_n, r_used > CNT_W'(TABLE_DEPTH))
    `ASSERT_CLK(a_write_state, i_clk, i_rst_n, o_tbl.wr_en |-> (r_state == S_UPDATE || r_state == S_MISS))
    `ASSERT_CLK(a_append_grows, i_clk, i_rst_n, (r_state == S_MISS && has_room) |=> (r_used == $past(r_used) + CNT_W'(1)))
    `ASSERT_CLK(a_done_holds, i_clk, i_rst_n, (r_state == S_DONE && !i_res_take) |=> (r_state == S_DONE))

endmodule

// ===== hdl/per_source_fixed_window_rate_limiter.sv =====
// Per-source fixed-window rate limiter. Each request carries a source address
// and the current time in seconds; the block finds the source in a table of up
// to TABLE_DEPTH tracked sources (never evicted), restarts or advances its
// window count (a new source is appended while there is room), and returns
// allowed and tracked. The table memory is read one entry per cycle in order
// of arrival, stopping at a match; then a check state tests the window age and
// an update state writes the entry back. o_in_stall stays high while a
// request is in work; a finished result sits in an output register so the
// next request can start while it waits. Configuration writes are always
// taken and must only be issued while the block is idle. The table needs no
// clearing after reset.
module per_source_fixed_window_rate_limiter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  psrl_pkg::t_in_item                   i_in_item,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output psrl_pkg::t_out_item                  o_out_item,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import psrl_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      busy;
    logic      res_valid;
    t_out_item res;
    logic      res_take;
    t_tbl_req  tbl_req;
    t_entry    rd_entry;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_seconds <= WINDOW_RESET;
            r_cfg.request_limit  <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW: r_cfg.window_seconds <= i_cfg_data[WINDOW_W-1:0];
                CFG_LIMIT:  r_cfg.request_limit  <= i_cfg_data[LIMIT_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Load the output register when empty or draining
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_in_stall  = busy;

    psrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_item),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_tbl       (tbl_req),
        .i_rd_entry  (rd_entry)
    );

    psrl_table u_table (
        .i_clk      (i_clk),
        .i_req      (tbl_req),
        .o_rd_entry (rd_entry)
    );

endmodule

// ===== tb/sv/per_source_fixed_window_rate_limiter_test.sv =====
`timescale 1ns / 100ps

module per_source_fixed_window_rate_limiter_test;
    import psrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = TABLE_DEPTH + 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOT_COUNT      = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    per_source_fixed_window_rate_limiter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the source table and live settings
    logic [ADDR_W-1:0]   src_addr  [TABLE_DEPTH];
    logic [COUNT_W-1:0]  src_count [TABLE_DEPTH];
    logic [TIME_W-1:0]   src_start [TABLE_DEPTH];
    int unsigned         sources_used = 0;
    logic [WINDOW_W-1:0] cur_window = WINDOW_RESET;
    logic [LIMIT_W-1:0]  cur_limit  = LIMIT_RESET;

    t_out_item           expected_verdicts[$];
    int unsigned         mismatch_count = 0;
    bit                  steady_flow = 1'b0;
    int unsigned         sink_hold = 0;
    logic [TIME_W-1:0]   wall_clock;
    logic [ADDR_W-1:0]   hot_sources [HOT_COUNT];

    always #5 i_clk = ~i_clk;

    // Decide one request against the shadow table and update it
    function automatic t_out_item judge_request(input t_in_item req);
        t_out_item         verdict;
        int unsigned       slot;
        logic [TIME_W-1:0] elapsed;
        verdict.allowed = 1'b1;
        verdict.tracked = 1'b0;
        slot = 0;
        while (slot < sources_used && src_addr[slot] != req.source_address) slot++;
        if (slot < sources_used) begin
            verdict.tracked = 1'b1;
            elapsed = req.time_now - src_start[slot];
            if (elapsed > {16'd0, cur_window}) begin
                // restart the window
                src_count[slot] = COUNT_W'(1);
                src_start[slot] = req.time_now;
            end else begin
                // advance the count, saturating one past the limit
                if (src_count[slot] < {1'b0, cur_limit} + 9'd1)
                    src_count[slot] = src_count[slot] + 9'd1;
                verdict.allowed = (src_count[slot] <= {1'b0, cur_limit});
            end
        end else if (sources_used < TABLE_DEPTH) begin
            src_addr[sources_used]  = req.source_address;
            src_count[sources_used] = COUNT_W'(1);
            src_start[sources_used] = req.time_now;
            sources_used++;
            verdict.tracked = 1'b1;
        end
        return verdict;
    endfunction

    // Step the request time: mostly slow, sometimes a jump or a step back
    function automatic void advance_clock();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick >= 98)
            wall_clock = wall_clock - $urandom_range(1, 1000);
        else if (pick >= 95)
            wall_clock = $urandom;
        else if (pick >= 85)
            wall_clock = wall_clock + $urandom_range(2, 20);
        else if (pick >= 55)
            wall_clock = wall_clock + 1;
    endfunction

    // Offer one request and record its verdict once taken
    task automatic send_request(input logic [ADDR_W-1:0] source,
                                input logic [TIME_W-1:0] stamp);
        t_in_item    req;
        int unsigned gap;
        req.source_address = source;
        req.time_now       = stamp;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        expected_verdicts.push_back(judge_request(req));
    endtask

    // Drop the request line and wait for every verdict
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Write one setting while the block is idle
    task automatic set_register(input logic [CFG_IDX_W-1:0]  index,
                                input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_WINDOW)
            cur_window = value;
        else
            cur_limit = value[LIMIT_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Settings straight out of reset: window edge and restart
    task automatic test_reset_settings();
        send_request(32'h0A00_0001, 32'd1000);
        send_request(32'h0A00_0001, 32'd1060);
        send_request(32'h0A00_0001, 32'd1121);
    endtask

    // Limit reached, saturation, restart, extremes, time going backwards
    task automatic test_window_and_limit();
        set_register(CFG_WINDOW, 16'd10);
        set_register(CFG_LIMIT, 16'd2);
        send_request(32'hC0A8_0001, 32'd100);
        send_request(32'hC0A8_0001, 32'd101);
        send_request(32'hC0A8_0001, 32'd102);
        send_request(32'hC0A8_0001, 32'd103);
        send_request(32'hC0A8_0001, 32'd111);
        send_request(32'hC0A8_0001, 32'd121);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd3);
        send_request(32'h0000_0000, 32'd0);
        send_request(32'hC0A8_0001, 32'd50);
    endtask

    // Lower the limit below a count already stored
    task automatic test_limit_lowered();
        set_register(CFG_LIMIT, 16'd4);
        send_request(32'hC0A8_0001, 32'd60);
        send_request(32'hC0A8_0001, 32'd61);
        send_request(32'hC0A8_0001, 32'd62);
        send_request(32'hC0A8_0001, 32'd63);
        set_register(CFG_LIMIT, 16'd1);
        send_request(32'hC0A8_0001, 32'd64);
    endtask

    // Zero limit rejects hits inside the window only
    task automatic test_zero_limit();
        set_register(CFG_LIMIT, 16'd0);
        send_request(32'hC0A8_0001, 32'd65);
        send_request(32'hC0A8_0001, 32'd66);
        send_request(32'h1234_5678, 32'd66);
    endtask

    // Zero window restarts on any change of time
    task automatic test_zero_window();
        set_register(CFG_WINDOW, 16'd0);
        set_register(CFG_LIMIT, 16'd3);
        send_request(32'hC0A8_0001, 32'd66);
        send_request(32'hC0A8_0001, 32'd66);
        send_request(32'hC0A8_0001, 32'd67);
    endtask

    // Fill the table, then new sources pass untracked
    task automatic test_table_full();
        set_register(CFG_WINDOW, WINDOW_RESET);
        set_register(CFG_LIMIT, CFG_DATA_W'(LIMIT_RESET));
        while (sources_used < TABLE_DEPTH) begin
            advance_clock();
            send_request($urandom, wall_clock);
        end
        repeat (3) send_request($urandom, wall_clock);
        send_request(src_addr[TABLE_DEPTH-1], wall_clock);
    endtask

    // Mostly a few busy sources, some other known ones, a few strangers
    task automatic test_random_traffic(input logic [WINDOW_W-1:0] window,
                                       input logic [LIMIT_W-1:0]  limit,
                                       input bit                  steady);
        logic [ADDR_W-1:0] source;
        int unsigned       pick;
        set_register(CFG_WINDOW, window);
        set_register(CFG_LIMIT, CFG_DATA_W'(limit));
        steady_flow = steady;
        foreach (hot_sources[h])
            hot_sources[h] = src_addr[$urandom_range(0, sources_used - 1)];
        repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                source = hot_sources[$urandom_range(0, HOT_COUNT - 1)];
            else if (pick < 95)
                source = src_addr[$urandom_range(0, sources_used - 1)];
            else
                source = $urandom;
            advance_clock();
            send_request(source, wall_clock);
        end
        steady_flow = 1'b0;
    endtask

    // Hold off the result side while requests keep coming
    task automatic test_output_backpressure();
        steady_flow = 1'b1;
        sink_hold   = 400;
        repeat (12) begin
            advance_clock();
            send_request(hot_sources[$urandom_range(0, HOT_COUNT - 1)], wall_clock);
        end
        steady_flow = 1'b0;
    endtask

    // Result side: random stall after each taken result, or a long hold
    initial begin : result_sink
        int unsigned pause;
        pause       = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                i_out_stall <= 1'b1;
            end else begin
                if (o_out_valid && !i_out_stall)
                    pause = steady_flow ? 0 : $urandom_range(0, 3);
                if (pause > 0) begin
                    pause--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Compare each taken result with the oldest pending verdict
    always @(posedge i_clk) begin : verdict_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                $error("result with no request pending: allowed %0b tracked %0b",
                       o_out_item.allowed, o_out_item.tracked);
                mismatch_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_out_item.allowed !== want.allowed) begin
                    $error("allowed: expected %0b, actual %0b",
                           want.allowed, o_out_item.allowed);
                    mismatch_count++;
                end
                if (o_out_item.tracked !== want.tracked) begin
                    $error("tracked: expected %0b, actual %0b",
                           want.tracked, o_out_item.tracked);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WINDOW;
        i_cfg_data  = '0;
        wall_clock  = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_window_and_limit();
        test_limit_lowered();
        test_zero_limit();
        test_zero_window();
        test_table_full();
        test_random_traffic(16'd1, 8'd1, 1'b0);
        test_output_backpressure();
        test_random_traffic(16'd65535, 8'd255, 1'b0);
        test_random_traffic(16'd8, 8'd4, 1'b1);
        test_random_traffic(16'd3, 8'd2, 1'b0);
        test_random_traffic(16'd20, 8'd10, 1'b0);
        test_random_traffic(WINDOW_RESET, LIMIT_RESET, 1'b0);

        // let any late result show up before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/psrl_pkg.sv
hdl/psrl_table.sv
hdl/psrl_ctrl.sv
hdl/per_source_fixed_window_rate_limiter.sv
tb/sv/per_source_fixed_window_rate_limiter_test.sv
